>>> hdl/assert_macros.svh
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of aclk outside reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Condition that must hold at every rising edge of aclk outside reset.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("invariant check failed");

`endif

>>> hdl/slle_pkg.sv
// Shared constants, request codes and types of the static linked list engine.
package slle_pkg;

    localparam int SLOTS      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = IDX_W;

    localparam logic [IDX_W-1:0] LIST_HEAD = IDX_W'(SLOTS - 1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 2);
    localparam logic [IDX_W-1:0] FREE_HEAD = '0;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_LOCATE = 3'd3;
    localparam logic [2:0] OP_PRED   = 3'd4;
    localparam logic [2:0] OP_SUCC   = 3'd5;
    localparam logic [2:0] OP_CLEAR  = 3'd6;
    localparam logic [2:0] OP_BAD    = 3'd7;

    typedef struct packed {
        logic [2:0]            op;
        logic                  pos_zero;
        logic [7:0]            pos;
        logic [DATA_WIDTH-1:0] val;
    } req_t;

endpackage

>>> hdl/slle_ram.sv
// Generic single write port RAM with one registered read port.
module slle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/slle_front.sv
// Front end: accepts request words, decodes them and queues them for the back end.
module slle_front import slle_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_req_type,
    input  logic [7:0]            s_position,
    input  logic [DATA_WIDTH-1:0] s_value_in,
    output logic                  q_valid,
    output req_t                  q_req,
    input  logic                  q_pop
);

    req_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    req_t       dec;

    always_comb begin
        dec.pos      = s_position;
        dec.pos_zero = (s_position == 8'd0);
        dec.val      = s_value_in;
        unique case (s_req_type)
            OP_INSERT, OP_DELETE, OP_GET, OP_LOCATE,
            OP_PRED, OP_SUCC, OP_CLEAR: dec.op = s_req_type;
            default:                    dec.op = OP_BAD;
        endcase
    end

    assign s_ready = (fill_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (fill_reg != 2'd0);
    assign q_req   = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (q_pop && q_valid);
        fill_next   = fill_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

>>> hdl/slle_back.sv
// Back end: walks the link store one node per cycle and produces the result word.
module slle_back import slle_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  req_t                  q_req,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_status,
    output logic [DATA_WIDTH-1:0] m_value_out,
    output logic [7:0]            m_slot_index,
    output logic [7:0]            m_length,
    output logic                  m_empty_res
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INS_J = 4'd1;
    localparam logic [3:0] ST_WALK  = 4'd2;
    localparam logic [3:0] ST_INS_K = 4'd3;
    localparam logic [3:0] ST_DEL_J = 4'd4;
    localparam logic [3:0] ST_DEL_F = 4'd5;
    localparam logic [3:0] ST_SRCH  = 4'd6;
    localparam logic [3:0] ST_SUCC  = 4'd7;
    localparam logic [3:0] ST_PRED1 = 4'd8;
    localparam logic [3:0] ST_PREDW = 4'd9;
    localparam logic [3:0] ST_CLR   = 4'd10;

    logic [3:0]            state_reg, state_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      free_reg, free_next;
    logic [IDX_W-1:0]      wm_reg, wm_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [IDX_W-1:0]      j_reg, j_next;
    logic [IDX_W-1:0]      k_reg, k_next;
    logic [7:0]            steps_reg, steps_next;
    logic [2:0]            op_reg, op_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [DATA_WIDTH-1:0] keep_reg, keep_next;

    logic                  m_valid_reg, m_valid_next;
    logic                  m_status_reg, m_status_next;
    logic [DATA_WIDTH-1:0] m_value_reg, m_value_next;
    logic [7:0]            m_slot_reg, m_slot_next;
    logic [7:0]            m_length_reg, m_length_next;
    logic                  m_empty_reg, m_empty_next;

    logic                  lwe;
    logic [IDX_W-1:0]      lwaddr, lwdata, link_q, lnk;
    logic                  dwe;
    logic [DATA_WIDTH-1:0] dat;

    logic                  out_free;
    logic                  fin, fin_status;
    logic [DATA_WIDTH-1:0] fin_value;
    logic [IDX_W-1:0]      fin_slot;

    slle_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_link_ram (
        .aclk  (aclk),
        .we    (lwe),
        .waddr (lwaddr),
        .wdata (lwdata),
        .raddr (cur_next),
        .rdata (link_q)
    );

    slle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SLOTS)) u_data_ram (
        .aclk  (aclk),
        .we    (dwe),
        .waddr (j_reg),
        .wdata (val_reg),
        .raddr (cur_next),
        .rdata (dat)
    );

    // Slots at or above the watermark were never allocated; their link still
    // follows the ascending free chain that reset implies, so it is derived here.
    always_comb begin
        priority if (cur_reg == LIST_HEAD) begin
            lnk = head_reg;
        end else if (cur_reg == FREE_HEAD) begin
            lnk = free_reg;
        end else if (cur_reg >= wm_reg) begin
            lnk = (cur_reg == LAST_SLOT) ? '0 : cur_reg + IDX_W'(1);
        end else begin
            lnk = link_q;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        free_next  = free_reg;
        wm_next    = wm_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        steps_next = steps_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        keep_next  = keep_reg;
        q_pop      = 1'b0;
        lwe        = 1'b0;
        lwaddr     = k_reg;
        lwdata     = j_reg;
        dwe        = 1'b0;
        fin        = 1'b0;
        fin_status = 1'b1;
        fin_value  = '0;
        fin_slot   = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop    = 1'b1;
                    op_next  = q_req.op;
                    val_next = q_req.val;
                    unique case (q_req.op)
                        OP_INSERT: begin
                            if (q_req.pos_zero || ({1'b0, q_req.pos} > {1'b0, cnt_reg} + 9'd1)
                                    || free_reg == '0) begin
                                fin = 1'b1;
                            end else begin
                                cur_next   = free_reg;
                                steps_next = q_req.pos - 8'd1;
                                state_next = ST_INS_J;
                            end
                        end
                        OP_DELETE, OP_GET: begin
                            if (q_req.pos_zero || q_req.pos > 8'(cnt_reg)) begin
                                fin = 1'b1;
                            end else begin
                                cur_next   = LIST_HEAD;
                                steps_next = (q_req.op == OP_GET) ? q_req.pos
                                                                  : q_req.pos - 8'd1;
                                state_next = ST_WALK;
                            end
                        end
                        OP_LOCATE, OP_SUCC, OP_PRED: begin
                            if (head_reg == '0) begin
                                fin = 1'b1;
                            end else begin
                                cur_next   = head_reg;
                                state_next = (q_req.op == OP_PRED) ? ST_PRED1 : ST_SRCH;
                            end
                        end
                        OP_CLEAR: begin
                            if (head_reg == '0) begin
                                fin        = 1'b1;
                                fin_status = 1'b0;
                                cnt_next   = '0;
                            end else begin
                                cur_next   = head_reg;
                                state_next = ST_CLR;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_INS_J: begin
                j_next    = cur_reg;
                free_next = lnk;
                if (cur_reg == wm_reg) begin
                    wm_next = wm_reg + IDX_W'(1);
                end
                cur_next   = LIST_HEAD;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (steps_reg != 8'd0) begin
                    steps_next = steps_reg - 8'd1;
                    cur_next   = lnk;
                end else begin
                    k_next = cur_reg;
                    priority if (op_reg == OP_GET) begin
                        fin        = 1'b1;
                        fin_status = 1'b0;
                        fin_value  = dat;
                        state_next = ST_IDLE;
                    end else if (op_reg == OP_DELETE) begin
                        cur_next   = lnk;
                        state_next = ST_DEL_J;
                    end else begin
                        // New node takes over the successor of its predecessor.
                        lwe        = 1'b1;
                        lwaddr     = j_reg;
                        lwdata     = lnk;
                        state_next = ST_INS_K;
                    end
                end
            end
            ST_INS_K: begin
                dwe = 1'b1;
                if (k_reg == LIST_HEAD) begin
                    head_next = j_reg;
                end else begin
                    lwe = 1'b1;
                end
                cnt_next   = cnt_reg + CNT_W'(1);
                fin        = 1'b1;
                fin_status = 1'b0;
                state_next = ST_IDLE;
            end
            ST_DEL_J: begin
                j_next    = cur_reg;
                keep_next = dat;
                if (k_reg == LIST_HEAD) begin
                    head_next = lnk;
                end else begin
                    lwe    = 1'b1;
                    lwdata = lnk;
                end
                state_next = ST_DEL_F;
            end
            ST_DEL_F: begin
                lwe        = 1'b1;
                lwaddr     = j_reg;
                lwdata     = free_reg;
                free_next  = j_reg;
                cnt_next   = cnt_reg - CNT_W'(1);
                fin        = 1'b1;
                fin_status = 1'b0;
                fin_value  = keep_reg;
                state_next = ST_IDLE;
            end
            ST_SRCH: begin
                if (dat == val_reg) begin
                    if (op_reg == OP_LOCATE) begin
                        fin        = 1'b1;
                        fin_status = 1'b0;
                        fin_slot   = cur_reg;
                        state_next = ST_IDLE;
                    end else if (lnk == '0) begin
                        fin        = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cur_next   = lnk;
                        state_next = ST_SUCC;
                    end
                end else if (lnk == '0) begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cur_next = lnk;
                end
            end
            ST_SUCC: begin
                fin        = 1'b1;
                fin_status = 1'b0;
                fin_value  = dat;
                state_next = ST_IDLE;
            end
            ST_PRED1: begin
                // The first element is never a match; it only seeds the predecessor.
                keep_next = dat;
                if (lnk == '0) begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cur_next   = lnk;
                    state_next = ST_PREDW;
                end
            end
            ST_PREDW: begin
                if (dat == val_reg) begin
                    fin        = 1'b1;
                    fin_status = 1'b0;
                    fin_value  = keep_reg;
                    state_next = ST_IDLE;
                end else if (lnk == '0) begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    keep_next = dat;
                    cur_next  = lnk;
                end
            end
            ST_CLR: begin
                if (lnk == '0) begin
                    // Splice the whole data list in front of the free chain.
                    lwe        = 1'b1;
                    lwaddr     = cur_reg;
                    lwdata     = free_reg;
                    free_next  = head_reg;
                    head_next  = '0;
                    cnt_next   = '0;
                    fin        = 1'b1;
                    fin_status = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    cur_next = lnk;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_slot_next   = m_slot_reg;
        m_length_next = m_length_reg;
        m_empty_next  = m_empty_reg;
        if (fin) begin
            m_valid_next  = 1'b1;
            m_status_next = fin_status;
            m_value_next  = fin_value;
            m_slot_next   = 8'(fin_slot);
            m_length_next = 8'(cnt_next);
            m_empty_next  = (cnt_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            free_reg    <= IDX_W'(1);
            wm_reg      <= IDX_W'(1);
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            free_reg    <= free_next;
            wm_reg      <= wm_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        steps_reg    <= steps_next;
        op_reg       <= op_next;
        val_reg      <= val_next;
        keep_reg     <= keep_next;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_slot_reg   <= m_slot_next;
        m_length_reg <= m_length_next;
        m_empty_reg  <= m_empty_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_value_out  = m_value_reg;
    assign m_slot_index = m_slot_reg;
    assign m_length     = m_length_reg;
    assign m_empty_res  = m_empty_reg;

endmodule

>>> hdl/static_linked_list_engine_core.sv
// Flow: a queued word is taken by the back end when it is idle and its result is free;
// it then walks one link at a time: get reads position p, insert allocates a free slot
// and walks to its predecessor, delete walks to the predecessor and then relinks, and a
// search walks until element n matches, reading one more node for a successor.
// The back end handles one word at a time; the link store has a single read port.
// Reset (aresetn low, synchronous) empties the list at once; no clearing pass runs.
module static_linked_list_engine_core import slle_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_req_type,
    input  logic [7:0]            s_position,
    input  logic [DATA_WIDTH-1:0] s_value_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_status,
    output logic [DATA_WIDTH-1:0] m_value_out,
    output logic [7:0]            m_slot_index,
    output logic [7:0]            m_length,
    output logic                  m_empty_res
);

`include "assert_macros.svh"

    logic q_valid;
    logic q_pop;
    req_t q_req;

    slle_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_position (s_position),
        .s_value_in (s_value_in),
        .q_valid    (q_valid),
        .q_req      (q_req),
        .q_pop      (q_pop)
    );

    slle_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_req        (q_req),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_value_out  (m_value_out),
        .m_slot_index (m_slot_index),
        .m_length     (m_length),
        .m_empty_res  (m_empty_res)
    );

    `ASSERT_IMPL(a_len_bound, m_valid, m_length <= 8'(SLOTS - 2))
    `ASSERT_IMPL(a_empty_flag, m_valid, m_empty_res == (m_length == 8'd0))
    `ASSERT_IMPL(a_slot_ok, m_valid && m_slot_index != 8'd0, !m_status)
    `ASSERT_ALWAYS(a_pop_valid, !q_pop || q_valid)

endmodule
